// ----- hdl/nps_pkg.sv -----
`default_nettype none

package nps_pkg;

  // Operation codes carried in a request
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  // Width of an exact squared distance: 2 * 65535^2 < 2^33
  localparam int DIST_W = 33;

  typedef struct packed {
    logic [1:0]          operation;
    logic signed [15:0]  coord_x;
    logic signed [15:0]  coord_y;
  } request_t;

  typedef struct packed {
    logic                found;
    logic signed [15:0]  near_x;
    logic signed [15:0]  near_y;
    logic [9:0]          near_index;
    logic [35:0]         dist_sq;
  } result_t;

  // Sequencer states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_FINISH = 4'b0100,
    ST_HOLD   = 4'b1000
  } state_t;

endpackage

`default_nettype wire

// ----- hdl/nearest_point_2d_search.sv -----
// Nearest stored 2D point by squared Euclidean distance.
// Request channel (request_valid / request_stall / request): each request is
// a clear, a load or a query. A load into a full store is dropped. Unused
// operation codes are ignored.
// A query scans the stored points one per cycle through the single read port
// of the point RAM, then a four-stage distance and compare pipeline drains.
// The result becomes valid once the scan and the pipeline drain are done,
// and the next request can be taken in that same cycle; request_stall is
// high from acceptance until then, and longer while an old result still
// waits.
// Result channel (result_valid / result_stall / result): one result per
// query, found = 0 with all fields 0 when the store is empty. Ties go to the
// lowest load index. The result sits in an output register, so clears and
// loads are still taken while a result waits; a new query scans while the
// old result waits and holds its own answer until the receiver takes it.
// Reset (rst, synchronous): empties the store and drops any pending result.
// The RAM keeps its contents but only entries below the count are read.
`default_nettype none

module nearest_point_2d_search #(
  parameter int MAX_POINTS = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               request_valid,
  output logic                    request_stall,
  input  wire nps_pkg::request_t  request,
  output logic                    result_valid,
  input  wire logic               result_stall,
  output nps_pkg::result_t        result
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int IW = (AW > 10) ? AW : 10;
  localparam logic [CW-1:0] COUNT_FULL = CW'(MAX_POINTS);

  nps_pkg::state_t state;

  logic [CW-1:0]              count;
  logic [CW-1:0]              issue_cnt;
  logic signed [15:0]         q_x;
  logic signed [15:0]         q_y;
  logic                       rd_valid;
  logic [AW-1:0]              rd_index;
  logic [31:0]                rd_data;

  logic                       have;
  logic [nps_pkg::DIST_W-1:0] best_d;
  logic [AW-1:0]              best_i;
  logic signed [15:0]         best_x;
  logic signed [15:0]         best_y;
  logic [IW-1:0]              best_i_ext;

  logic                       d_valid;
  logic [AW-1:0]              d_index;
  logic signed [15:0]         d_x;
  logic signed [15:0]         d_y;
  logic [nps_pkg::DIST_W-1:0] d_dist;
  logic                       d_busy;

  logic accept;
  logic do_load;
  logic issue_en;
  logic scan_done;
  logic load_result;

  // Handshake and control strobes
  assign request_stall = (state != nps_pkg::ST_IDLE);
  assign accept        = request_valid && !request_stall;
  assign do_load       = accept && (request.operation == nps_pkg::OP_LOAD)
                         && (count < COUNT_FULL);
  assign issue_en      = (state == nps_pkg::ST_SCAN) && (issue_cnt < count);
  assign scan_done     = (state == nps_pkg::ST_SCAN) && !issue_en && !rd_valid
                         && !d_busy;
  assign load_result   = (state == nps_pkg::ST_FINISH)
                         && (!result_valid || !result_stall);

  // Point store: x in the low half, y in the high half
  nps_ram #(
    .WIDTH (32),
    .DEPTH (MAX_POINTS)
  ) u_ram (
    .clk   (clk),
    .we    (do_load),
    .waddr (count[AW-1:0]),
    .wdata ({request.coord_y, request.coord_x}),
    .raddr (issue_cnt[AW-1:0]),
    .rdata (rd_data)
  );

  // Shared distance unit
  nps_dist #(
    .IW (AW)
  ) u_dist (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rd_valid),
    .in_index  (rd_index),
    .px        (rd_data[15:0]),
    .py        (rd_data[31:16]),
    .qx        (q_x),
    .qy        (q_y),
    .out_valid (d_valid),
    .out_index (d_index),
    .out_x     (d_x),
    .out_y     (d_y),
    .sum_sq    (d_dist),
    .busy      (d_busy)
  );

  // Sequencer, point count and read issue
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= nps_pkg::ST_IDLE;
      count     <= '0;
      issue_cnt <= '0;
      rd_valid  <= 1'b0;
    end else begin
      rd_valid <= issue_en;
      case (state)
        nps_pkg::ST_IDLE: begin
          if (accept) begin
            case (request.operation)
              nps_pkg::OP_CLEAR: count <= '0;
              nps_pkg::OP_LOAD: begin
                if (do_load) begin
                  count <= count + 1'b1;
                end
              end
              nps_pkg::OP_QUERY: begin
                issue_cnt <= '0;
                state     <= nps_pkg::ST_SCAN;
              end
              default: ;
            endcase
          end
        end
        nps_pkg::ST_SCAN: begin
          if (issue_en) begin
            issue_cnt <= issue_cnt + 1'b1;
          end
          if (scan_done) begin
            state <= nps_pkg::ST_FINISH;
          end
        end
        nps_pkg::ST_FINISH: begin
          if (load_result) begin
            state <= nps_pkg::ST_IDLE;
          end
        end
        default: state <= nps_pkg::ST_IDLE;
      endcase
    end
  end

  // Query point and read index tag
  always_ff @(posedge clk) begin
    if (accept) begin
      q_x <= request.coord_x;
      q_y <= request.coord_y;
    end
    rd_index <= issue_cnt[AW-1:0];
  end

  // Running best; strictly smaller wins so ties keep the lowest index
  always_ff @(posedge clk) begin
    if (rst) begin
      have <= 1'b0;
    end else if (accept && (request.operation == nps_pkg::OP_QUERY)) begin
      have <= 1'b0;
    end else if (d_valid && (!have || (d_dist < best_d))) begin
      have <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (d_valid && (!have || (d_dist < best_d))) begin
      best_d <= d_dist;
      best_i <= d_index;
      best_x <= d_x;
      best_y <= d_y;
    end
  end

  assign best_i_ext = IW'(best_i);

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_result) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      result.found      <= have;
      result.near_x     <= have ? best_x : 16'sd0;
      result.near_y     <= have ? best_y : 16'sd0;
      result.near_index <= have ? best_i_ext[9:0] : 10'd0;
      result.dist_sq    <= have ? 36'(best_d) : 36'd0;
    end
  end

`ifndef SYNTH
  // Store count never passes capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_FULL)
    else $error("point count above capacity");

  // Store is not modified while a query is scanning
  a_count_stable: assert property (@(posedge clk) disable iff (rst)
    (state == nps_pkg::ST_SCAN) |=> $stable(count))
    else $error("point count changed during scan");

  // An empty-store answer carries all-zero fields
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.found) |->
      (result.dist_sq == 36'd0 && result.near_index == 10'd0
       && result.near_x == 16'sd0 && result.near_y == 16'sd0))
    else $error("empty result has nonzero fields");
`endif

endmodule

`default_nettype wire

// ----- hdl/nps_ram.sv -----
`default_nettype none

module nps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                                       clk,
  input  wire logic                                       we,
  input  wire logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                           wdata,
  input  wire logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] raddr,
  output logic      [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hdl/nps_dist.sv -----
`default_nettype none

// Squared distance unit: abs difference, square, sum, one register each.
module nps_dist #(
  parameter int IW = 10
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  input  wire logic [IW-1:0]                in_index,
  input  wire logic signed [15:0]           px,
  input  wire logic signed [15:0]           py,
  input  wire logic signed [15:0]           qx,
  input  wire logic signed [15:0]           qy,
  output logic                              out_valid,
  output logic [IW-1:0]                     out_index,
  output logic signed [15:0]                out_x,
  output logic signed [15:0]                out_y,
  output logic [nps_pkg::DIST_W-1:0]        sum_sq,
  output logic                              busy
);

  logic signed [16:0] dx;
  logic signed [16:0] dy;
  logic [16:0]        mx;
  logic [16:0]        my;

  logic               va;
  logic               vb;
  logic [15:0]        ax;
  logic [15:0]        ay;
  logic [31:0]        sx;
  logic [31:0]        sy;
  logic [IW-1:0]      ia;
  logic [IW-1:0]      ib;
  logic signed [15:0] xa;
  logic signed [15:0] ya;
  logic signed [15:0] xb;
  logic signed [15:0] yb;

  // Differences on 17 bits; magnitude always fits in 16
  always_comb begin
    dx = {px[15], px} - {qx[15], qx};
    dy = {py[15], py} - {qy[15], qy};
    mx = dx[16] ? (17'd0 - dx) : dx;
    my = dy[16] ? (17'd0 - dy) : dy;
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      va        <= in_valid;
      vb        <= va;
      out_valid <= vb;
    end
  end

  // Datapath stages
  always_ff @(posedge clk) begin
    ax        <= mx[15:0];
    ay        <= my[15:0];
    ia        <= in_index;
    xa        <= px;
    ya        <= py;
    sx        <= ax * ax;
    sy        <= ay * ay;
    ib        <= ia;
    xb        <= xa;
    yb        <= ya;
    sum_sq    <= {1'b0, sx} + {1'b0, sy};
    out_index <= ib;
    out_x     <= xb;
    out_y     <= yb;
  end

  assign busy = va | vb | out_valid;

endmodule

`default_nettype wire
